// ----- hw/rtl/adc_pkg.sv -----
// Shared constants, types and helper functions of the disc coverage block.
`timescale 1ns / 1ps
`default_nettype none

package adc_pkg;

  // fixed-point format of centre and radius
  localparam int FRAC_BITS = 4;
  localparam int ONE_FX    = 1 << FRAC_BITS;
  localparam int HALF_FX   = 1 << (FRAC_BITS - 1);
  localparam int REG_W     = 12;

  // configuration port
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cfg_reg_t;

  // defaults handed to the top level
  localparam int COORD_BITS_DEFAULT  = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // scale = (1024 << FRAC_BITS) / span with span = 4 * ONE_FX * r, i.e. 256 / r
  localparam int SCALE_W        = 9;
  localparam int SCALE_IDX_W    = $clog2(SCALE_W);
  localparam int SCALE_DIVIDEND = (1024 << FRAC_BITS) / (4 * ONE_FX);
  localparam int OUTER_W        = REG_W + 1;
  localparam int OUTER_SQ_W     = 2 * OUTER_W;
  // (r+16)^2 * floor(256/r) peaks at 73984 over the radii with a non-zero scale
  localparam int SOS_W          = 17;

  // coverage level
  localparam int LEVEL_SHIFT = 8 + FRAC_BITS;
  localparam int LEVEL_ONE   = 1 << LEVEL_SHIFT;
  localparam int LEVEL_FULL  = 3 << LEVEL_SHIFT;

  localparam logic [7:0] PIXEL_FULL  = 8'hFF;
  localparam logic [7:0] PIXEL_BLEND = 8'hC0;

  typedef struct packed {
    logic [SCALE_W-1:0] factor;
    logic [SOS_W-1:0]   outer_sq;
    logic               busy;
  } scale_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_DIVIDE,
    SC_SQUARE,
    SC_SCALE
  } scale_state_t;

  // signed width of a centre offset 16*p + 8 - c
  function automatic int dx_width(input int coord_bits);
    return ((coord_bits + FRAC_BITS > REG_W) ? coord_bits + FRAC_BITS : REG_W) + 1;
  endfunction

  // queue word: x, y, draw flag, dx, dy
  function automatic int word_width(input int coord_bits);
    return 2 * coord_bits + 1 + 2 * dx_width(coord_bits);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adc_if.sv -----
// Valid/ready channel interfaces for pixel words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface adc_pixel_if #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface adc_result_if #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  write_enable;
  logic [7:0]            pixel_value;

  modport source (output valid, output out_x, output out_y, output write_enable,
                  output pixel_value, input ready);
  modport sink   (input valid, input out_x, input out_y, input write_enable,
                  input pixel_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adc_scale_unit.sv -----
// Radius-derived scale factor: restoring divider followed by two multiply steps.
`timescale 1ns / 1ps
`default_nettype none

module adc_scale_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [adc_pkg::REG_W-1:0] radius,
  output adc_pkg::scale_t                scale
);
  import adc_pkg::*;

  localparam logic [SCALE_W-1:0] DIVIDEND = SCALE_W'(SCALE_DIVIDEND);

  scale_state_t           state, state_next;
  logic [REG_W-1:0]       divisor, divisor_next;
  logic [REG_W-1:0]       rem, rem_next;
  logic [SCALE_W-1:0]     quot, quot_next;
  logic [SCALE_IDX_W-1:0] bit_idx, bit_idx_next;
  logic [OUTER_SQ_W-1:0]  outer_sq, outer_sq_next;
  logic [SCALE_W-1:0]     factor, factor_next;
  logic [SOS_W-1:0]       sos, sos_next;

  logic [REG_W:0]                 trial;
  logic [OUTER_W-1:0]             outer;
  logic [OUTER_SQ_W+SCALE_W-1:0]  sos_full;

  always_comb begin
    trial    = {rem, DIVIDEND[bit_idx]};
    outer    = OUTER_W'(divisor) + OUTER_W'(ONE_FX);
    sos_full = outer_sq * factor;

    state_next    = state;
    divisor_next  = divisor;
    rem_next      = rem;
    quot_next     = quot;
    bit_idx_next  = bit_idx;
    outer_sq_next = outer_sq;
    factor_next   = factor;
    sos_next      = sos;

    case (state)
      SC_IDLE: begin
      end
      SC_DIVIDE: begin
        // one quotient bit a cycle, MSB first
        if (trial >= {1'b0, divisor}) begin
          rem_next           = REG_W'(trial - {1'b0, divisor});
          quot_next[bit_idx] = 1'b1;
        end else begin
          rem_next = trial[REG_W-1:0];
        end
        bit_idx_next = bit_idx - 1'b1;
        if (bit_idx == '0) begin
          state_next = SC_SQUARE;
        end
      end
      SC_SQUARE: begin
        // zero radius draws nothing
        factor_next   = (divisor == '0) ? '0 : quot;
        outer_sq_next = outer * outer;
        state_next    = SC_SCALE;
      end
      SC_SCALE: begin
        sos_next   = sos_full[SOS_W-1:0];
        state_next = SC_IDLE;
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase

    if (start) begin
      divisor_next = radius;
      rem_next     = '0;
      quot_next    = '0;
      bit_idx_next = SCALE_IDX_W'(SCALE_W - 1);
      state_next   = SC_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SC_IDLE;
      factor <= '0;
      sos    <= '0;
    end else begin
      state  <= state_next;
      factor <= factor_next;
      sos    <= sos_next;
    end
  end

  always_ff @(posedge clk) begin
    divisor  <= divisor_next;
    rem      <= rem_next;
    quot     <= quot_next;
    bit_idx  <= bit_idx_next;
    outer_sq <= outer_sq_next;
  end

  assign scale.factor   = factor;
  assign scale.outer_sq = sos;
  assign scale.busy     = (state != SC_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/adc_front.sv -----
// Front end: accept pixel words, test the bounding box, form centre offsets.
`timescale 1ns / 1ps
`default_nettype none

module adc_front #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEFAULT,
  parameter int WORD_W     = adc_pkg::word_width(adc_pkg::COORD_BITS_DEFAULT)
) (
  adc_pixel_if.sink                      pixel_in,
  input  wire logic [adc_pkg::REG_W-1:0] center_x,
  input  wire logic [adc_pkg::REG_W-1:0] center_y,
  input  wire logic [adc_pkg::REG_W-1:0] radius,
  input  wire logic                      busy,
  input  wire logic                      queue_full,
  output logic                           push,
  output logic [WORD_W-1:0]              word
);
  import adc_pkg::*;

  localparam int DX_W  = dx_width(COORD_BITS);
  localparam int PF_W  = COORD_BITS + FRAC_BITS;
  localparam int BOX_W = ((PF_W + 1 > REG_W + 1) ? PF_W + 1 : REG_W + 1) + 1;

  localparam logic [FRAC_BITS-1:0] FX_HALF = FRAC_BITS'(HALF_FX);
  localparam logic [FRAC_BITS-1:0] FX_LAST = FRAC_BITS'(ONE_FX - 1);

  logic [PF_W-1:0]    x_mid, y_mid, x_last, y_last, y_first;
  logic [PF_W:0]      x_next;
  logic [BOX_W-1:0]   cx_hi, cy_hi;
  logic               in_box, draw;
  logic signed [DX_W-1:0] dx, dy;

  always_comb begin
    x_mid   = {pixel_in.pixel_x, FX_HALF};
    y_mid   = {pixel_in.pixel_y, FX_HALF};
    x_last  = {pixel_in.pixel_x, FX_LAST};
    y_last  = {pixel_in.pixel_y, FX_LAST};
    y_first = {pixel_in.pixel_y, {FRAC_BITS{1'b0}}};
    x_next  = {({1'b0, pixel_in.pixel_x} + 1'b1), {FRAC_BITS{1'b0}}};
    cx_hi   = BOX_W'(center_x) + BOX_W'(radius);
    cy_hi   = BOX_W'(center_y) + BOX_W'(radius);

    // box edges moved to the pixel side so nothing goes negative
    in_box = (BOX_W'(x_last) + BOX_W'(radius) >= BOX_W'(center_x)) &&
             (BOX_W'(x_next) <= cx_hi) &&
             (BOX_W'(y_last) + BOX_W'(radius) >= BOX_W'(center_y)) &&
             (BOX_W'(y_first) < cy_hi);
    draw   = (radius != '0) && in_box;

    dx = $signed(DX_W'(x_mid) - DX_W'(center_x));
    dy = $signed(DX_W'(y_mid) - DX_W'(center_y));
  end

  assign pixel_in.ready = !busy && !queue_full;
  assign push           = pixel_in.valid && pixel_in.ready;
  assign word           = {pixel_in.pixel_x, pixel_in.pixel_y, draw, dx, dy};

endmodule

`default_nettype wire

// ----- hw/rtl/adc_queue.sv -----
// Short FIFO between the front end and the coverage pipeline.
`timescale 1ns / 1ps
`default_nettype none

module adc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = adc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_word,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  head_valid,
  output logic                  full
);
  import adc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adc_back.sv -----
// Coverage pipeline: squares, distance sum, scaling, level and output register.
`timescale 1ns / 1ps
`default_nettype none

module adc_back #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEFAULT,
  parameter int WORD_W     = adc_pkg::word_width(adc_pkg::COORD_BITS_DEFAULT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORD_W-1:0] head,
  input  wire logic              head_valid,
  output logic                   pop,
  input  wire adc_pkg::scale_t   scale,
  adc_result_if.source           result_out
);
  import adc_pkg::*;

  localparam int DX_W   = dx_width(COORD_BITS);
  localparam int SQ_W   = 2 * (DX_W - 1);
  localparam int DS_W   = SQ_W + 1;
  localparam int PROD_W = DS_W + SCALE_W;
  localparam int DIFF_W = PROD_W + 1;

  // head word layout
  localparam int DY_LO = 0;
  localparam int DX_LO = DX_W;
  localparam int DR_B  = 2 * DX_W;
  localparam int Y_LO  = DR_B + 1;
  localparam int X_LO  = Y_LO + COORD_BITS;

  logic advance;
  logic v1, v2, v3, v4;

  logic signed [DX_W-1:0]   h_dx, h_dy;
  logic signed [2*DX_W-1:0] dx_prod, dy_prod;

  logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic                  d1, d2, d3;
  logic [SQ_W-1:0]       dxsq, dysq;
  logic [DS_W-1:0]       ds;
  logic [PROD_W-1:0]     prod;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-2:0]        mag;
  logic [1:0]               level;
  logic                     we_next, we;
  logic [7:0]               value_next, value;

  assign h_dx    = $signed(head[DX_LO +: DX_W]);
  assign h_dy    = $signed(head[DY_LO +: DX_W]);
  assign dx_prod = h_dx * h_dx;
  assign dy_prod = h_dy * h_dy;

  // hold the whole pipeline while the output word waits
  assign advance = !v4 || result_out.ready;
  assign pop     = advance && head_valid;

  always_comb begin
    diff  = $signed({1'b0, PROD_W'(scale.outer_sq)}) - $signed({1'b0, prod});
    mag   = diff[DIFF_W-2:0];
    level = mag[LEVEL_SHIFT +: 2];
    we_next = d3 && !diff[DIFF_W-1] && (mag >= (DIFF_W-1)'(LEVEL_ONE));
    if (!we_next) begin
      value_next = '0;
    end else if (mag >= (DIFF_W-1)'(LEVEL_FULL)) begin
      value_next = PIXEL_FULL;
    end else begin
      value_next = PIXEL_BLEND | {2'b00, level, level, level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x1    <= head[X_LO +: COORD_BITS];
      y1    <= head[Y_LO +: COORD_BITS];
      d1    <= head[DR_B];
      dxsq  <= dx_prod[SQ_W-1:0];
      dysq  <= dy_prod[SQ_W-1:0];

      x2    <= x1;
      y2    <= y1;
      d2    <= d1;
      ds    <= DS_W'(dxsq) + DS_W'(dysq);

      x3    <= x2;
      y3    <= y2;
      d3    <= d2;
      prod  <= ds * scale.factor;

      x4    <= x3;
      y4    <= y3;
      we    <= we_next;
      value <= value_next;
    end
  end

  assign result_out.valid        = v4;
  assign result_out.out_x        = x4;
  assign result_out.out_y        = y4;
  assign result_out.write_enable = we;
  assign result_out.pixel_value  = value;

endmodule

`default_nettype wire

// ----- hw/rtl/antialiased_disc_coverage.sv -----
// Antialiased disc coverage evaluator: top level with configuration registers.
//
// Usage: write centre x, centre y and radius (1/16 pixel units) on the plain
// write port while the block is idle, then stream pixel words on pixel_in.
// Every accepted pixel word yields exactly one result word on result_out,
// in order: the echoed coordinates, a write enable and the 8-bit colour.
// Each accepted pixel word passes a queue slot, then the squares, distance
// sum, scaling and level registers in order, to reach its result word.
// Throughput: one pixel word per clock while result_out is not stalled and
// the scale divider is idle. A radius write starts the divider, which
// produces one quotient bit a cycle and then takes two multiply steps;
// pixel_in.ready stays low until it is done. Reset clears the registers and
// the derived scale, so nothing is drawn until a radius is written.
// When the receiver stalls, the result word holds and the pipeline freezes;
// pixel words are still taken into the queue until it fills.
`timescale 1ns / 1ps
`default_nettype none

module antialiased_disc_coverage #(
  parameter int COORD_BITS  = adc_pkg::COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = adc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  adc_pixel_if.sink                            pixel_in,
  adc_result_if.source                         result_out,
  input  wire logic                            cfg_we,
  input  wire logic [adc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [adc_pkg::REG_W-1:0]       cfg_data
);
  import adc_pkg::*;

  localparam int WORD_W = word_width(COORD_BITS);

  logic [REG_W-1:0]  center_x, center_y, radius;
  scale_t            scale;
  logic              radius_start;
  logic              push, pop, queue_full, head_valid;
  logic [WORD_W-1:0] push_word, head;

  // configuration registers; unknown indexes are dropped
  assign radius_start = cfg_we && (cfg_index == REG_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // derive scale and scaled outer square from each new radius
  adc_scale_unit u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (radius_start),
    .radius (cfg_data),
    .scale  (scale)
  );

  // classify each pixel word: box test and centre offsets
  adc_front #(
    .COORD_BITS (COORD_BITS),
    .WORD_W     (WORD_W)
  ) u_front (
    .pixel_in   (pixel_in),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .busy       (scale.busy),
    .queue_full (queue_full),
    .push       (push),
    .word       (push_word)
  );

  // decouple the front end from output stalls
  adc_queue #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  // distance, scaling and coverage level
  adc_back #(
    .COORD_BITS (COORD_BITS),
    .WORD_W     (WORD_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .scale      (scale),
    .result_out (result_out)
  );

`ifndef ASSERT_OFF
  // no pixel word is taken while the divider works
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    scale.busy |-> !pixel_in.ready)
    else $error("pixel accepted while scale derivation is running");

  // a written pixel always carries the blend or full colour pattern
  a_written_colour: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.write_enable) |->
      (result_out.pixel_value[7:6] == 2'b11))
    else $error("written pixel lacks the colour base bits");

  // an unwritten pixel carries colour zero
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.write_enable) |->
      (result_out.pixel_value == 8'h00))
    else $error("unwritten pixel has a non-zero colour");

  // zero radius writes nothing
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && (radius == '0)) |-> !result_out.write_enable)
    else $error("pixel written with zero radius");
`endif

endmodule

`default_nettype wire

// ----- bench/antialiased_disc_coverage_tb.sv -----
// Self-checking bench for the disc coverage block: directed and random pixel words.
`timescale 1ns / 1ps

module antialiased_disc_coverage_tb;
  import adc_pkg::*;

  // Pixel coordinates are 8 bits wide at the default configuration.
  localparam int COORD_W = 8;

  // Index 3 decodes to no register; the block must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // Covers the path from acceptance to result, plus margin for the output stage.
  localparam int DRAIN_CYCLES = 12;
  // Receiver hold-off long enough to fill the queue and freeze the pipeline.
  localparam int LONG_STALL   = 200;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               we;
    logic [7:0]         value;
  } coverage_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  adc_pixel_if  #(.COORD_BITS(COORD_W)) pix_ch ();
  adc_result_if #(.COORD_BITS(COORD_W)) res_ch ();

  antialiased_disc_coverage #(
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_ch),
    .result_out(res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Disc settings as the block should hold them, and the derived scale.
  logic [REG_W-1:0]   disc_cx;
  logic [REG_W-1:0]   disc_cy;
  logic [REG_W-1:0]   disc_r;
  logic [SCALE_W-1:0] disc_scale;
  logic [31:0]        disc_outer_sq;

  pixel_t    pixel_queue[$];   // words waiting to be offered
  coverage_t coverage_due[$];  // predicted result words, oldest first
  pixel_t    next_pixel;
  coverage_t got_word;
  coverage_t want_word;

  logic pixel_taken;
  int   idle_pct = 35;
  int   stall_requests = 0;
  int   stalls_served = 0;
  int   stall_left = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the scale once per radius write, as the block's divider does.
  task automatic derive_disc_scale();
    longint rr;
    longint span;
    rr   = longint'(disc_r);
    span = (rr + ONE_FX) * (rr + ONE_FX) - (rr - ONE_FX) * (rr - ONE_FX);
    if (disc_r == 0 || span <= 0) begin
      disc_scale    = '0;
      disc_outer_sq = '0;
    end else begin
      disc_scale    = SCALE_W'((longint'(1024) << FRAC_BITS) / span);
      disc_outer_sq = 32'((rr + ONE_FX) * (rr + ONE_FX) * longint'(disc_scale));
    end
  endtask

  // Coverage of one pixel against the disc currently held.
  function automatic coverage_t predict_coverage(input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
    longint    x, y, cx, cy, r, dx, dy, ds, diff;
    logic [1:0] level;
    coverage_t c;
    x  = px;
    y  = py;
    cx = disc_cx;
    cy = disc_cy;
    r  = disc_r;
    c.x     = px;
    c.y     = py;
    c.we    = 1'b0;
    c.value = 8'h00;
    // floor on the left, top and right edges of the box, ceil on the bottom
    if (r != 0 &&
        ONE_FX * x + (ONE_FX - 1) >= cx - r && ONE_FX * (x + 1) <= cx + r &&
        ONE_FX * y + (ONE_FX - 1) >= cy - r && ONE_FX * y < cy + r) begin
      dx   = ONE_FX * x + HALF_FX - cx;
      dy   = ONE_FX * y + HALF_FX - cy;
      ds   = dx * dx + dy * dy;
      diff = longint'(disc_outer_sq) - ds * longint'(disc_scale);
      if (diff >= (longint'(1) << LEVEL_SHIFT)) begin
        c.we = 1'b1;
        if (diff >= (longint'(3) << LEVEL_SHIFT)) begin
          c.value = PIXEL_FULL;
        end else begin
          level   = 2'(diff >>> LEVEL_SHIFT);
          c.value = PIXEL_BLEND | {2'b00, level, level, level};
        end
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Pick a coordinate near the bounding box along one axis, clamped to the frame.
  function automatic logic [COORD_W-1:0] pick_near(input int centre, input int reach);
    int lo;
    int hi;
    lo = ((centre - reach) >>> FRAC_BITS) - 1;
    hi = ((centre + reach) >>> FRAC_BITS) + 1;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (lo > hi) lo = hi;
    return COORD_W'($urandom_range(hi, lo));
  endfunction

  task automatic queue_pixel(input int x, input int y);
    pixel_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    pixel_queue.push_back(p);
  endtask

  // Hold until nothing is queued, offered or pending, then let the pipe empty.
  task automatic wait_for_drain();
    @(posedge clk);
    while (pixel_queue.size() != 0 || pix_ch.valid || coverage_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write for one cycle and mirror it in the local copy.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CENTER_X: disc_cx = val;
      REG_CENTER_Y: disc_cy = val;
      REG_RADIUS: begin
        disc_r = val;
        derive_disc_scale();
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Reconfigure only once idle; radius goes last so the divider runs while
  // the first words of the next phase wait on ready.
  task automatic load_disc(input int cx, input int cy, input int r, input bit poke_unused);
    wait_for_drain();
    @(negedge clk);
    write_reg(REG_CENTER_X, REG_W'(cx));
    write_reg(REG_CENTER_Y, REG_W'(cy));
    if (poke_unused) write_reg(REG_UNUSED, REG_W'($urandom_range(4095, 0)));
    write_reg(REG_RADIUS, REG_W'(r));
    cfg_we <= 1'b0;
  endtask

  // Sender: offer the next queued word once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pixel_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_pixel = pixel_queue.pop_front();
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= next_pixel.x;
        pix_ch.pixel_y <= next_pixel.y;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (stall_requests != stalls_served) begin
      stalls_served <= stalls_served + 1;
      stall_left    <= LONG_STALL;
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: predict at acceptance of a pixel word, check each result word.
  always @(posedge clk) begin
    pixel_taken <= !rst && pix_ch.valid && pix_ch.ready;
    if (!rst && pix_ch.valid && pix_ch.ready)
      coverage_due.push_back(predict_coverage(pix_ch.pixel_x, pix_ch.pixel_y));
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_word.x     = res_ch.out_x;
      got_word.y     = res_ch.out_y;
      got_word.we    = res_ch.write_enable;
      got_word.value = res_ch.pixel_value;
      if (coverage_due.size() == 0) begin
        report_mismatch($sformatf("result word (%0d,%0d) with nothing pending",
                                  got_word.x, got_word.y));
      end else begin
        want_word = coverage_due.pop_front();
        if (got_word.x !== want_word.x)
          report_mismatch($sformatf("out_x %0d, want %0d", got_word.x, want_word.x));
        if (got_word.y !== want_word.y)
          report_mismatch($sformatf("out_y %0d, want %0d", got_word.y, want_word.y));
        if (got_word.we !== want_word.we)
          report_mismatch($sformatf("write_enable %b, want %b at (%0d,%0d)",
                                    got_word.we, want_word.we, want_word.x, want_word.y));
        if (got_word.value !== want_word.value)
          report_mismatch($sformatf("pixel_value %h, want %h at (%0d,%0d)",
                                    got_word.value, want_word.value,
                                    want_word.x, want_word.y));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[antialiased_disc_coverage] ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    int random_sent;
    int count;
    int sel;
    int cx, cy, r;
    int i;

    // Hold every input at a known value from time zero.
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_CENTER_X;
    cfg_data       = '0;
    pix_ch.valid   = 1'b0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    res_ch.ready   = 1'b0;
    disc_cx        = '0;
    disc_cy        = '0;
    disc_r         = '0;
    disc_scale     = '0;
    disc_outer_sq  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero radius straight out of reset: nothing may be written.
    queue_pixel(0, 0);
    queue_pixel(255, 255);
    queue_pixel(0, 255);
    queue_pixel(255, 0);
    queue_pixel(128, 128);

    // Mid-frame disc of radius five pixels; walk across its rim to hit every level.
    // The unused index is poked with all ones and must leave the centre alone.
    load_disc(2048, 2048, 80, 1'b0);
    wait_for_drain();
    @(negedge clk);
    write_reg(REG_UNUSED, 12'hFFF);
    cfg_we <= 1'b0;
    queue_pixel(128, 128);
    queue_pixel(131, 128);
    queue_pixel(132, 128);
    queue_pixel(133, 128);
    queue_pixel(123, 128);
    queue_pixel(124, 128);
    queue_pixel(128, 123);
    queue_pixel(128, 132);
    queue_pixel(128, 133);
    queue_pixel(130, 131);
    queue_pixel(127, 127);
    queue_pixel(0, 0);
    queue_pixel(255, 255);

    // Radius above 256: scale truncates to zero, so no pixel is written.
    load_disc(4095, 0, 300, 1'b0);
    queue_pixel(255, 0);
    queue_pixel(250, 3);
    queue_pixel(240, 10);

    // Largest radius, centre in the far corner.
    load_disc(0, 4095, 4095, 1'b0);
    queue_pixel(0, 255);
    queue_pixel(5, 250);

    // Smallest radius at the top corner of the coordinate range.
    load_disc(4095, 4095, 1, 1'b0);
    queue_pixel(255, 255);
    queue_pixel(254, 255);

    // Random phases. Each phase boundary pauses the sender until every
    // expected word is back, then reconfigures.
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      sel = $urandom_range(99);
      if (sel < 10)      cx = 0;
      else if (sel < 20) cx = 4095;
      else               cx = $urandom_range(4095, 0);
      sel = $urandom_range(99);
      if (sel < 10)      cy = 0;
      else if (sel < 20) cy = 4095;
      else               cy = $urandom_range(4095, 0);
      sel = $urandom_range(99);
      if (sel < 7)       r = 0;
      else if (sel < 14) r = $urandom_range(4095, 257);
      else if (sel < 18) r = 256;
      else if (sel < 45) r = $urandom_range(255, 1);
      else               r = $urandom_range(100, 1);

      count = $urandom_range(90, 30);
      // One long stretch with no idling on either side.
      if (phase == 3) begin
        count = 200;
      end
      load_disc(cx, cy, r, $urandom_range(99) < 25);
      idle_pct = (phase == 3) ? 0 : 35;

      for (i = 0; i < count; i++) begin
        // Mostly pixels around the box so the rim and levels get exercised.
        if ($urandom_range(99) < 80)
          queue_pixel(pick_near(cx, r), pick_near(cy, r));
        else
          queue_pixel($urandom_range(255, 0), $urandom_range(255, 0));
      end
      // Hold the receiver off while words keep coming: queue fills, input stalls.
      if (phase == 5) stall_requests++;
      random_sent += count;
    end

    wait_for_drain();
    if (mismatches == 0) begin
      $display("[antialiased_disc_coverage] OK");
    end else begin
      $display("[antialiased_disc_coverage] ERROR");
    end
    $finish;
  end

endmodule
